FILE: design/teo_pkg.sv
// Shared types, constants and the orientation test for the edge ring orderer.
package teo_pkg;

    localparam int ID_BITS  = 20;
    localparam int POS_BITS = 5;

    typedef logic [ID_BITS-1:0]  t_id;
    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [3:0][ID_BITS-1:0] t_quad;

    // Orientation test answers
    localparam logic [1:0] ORI_BAD  = 2'd0;
    localparam logic [1:0] ORI_ODD  = 2'd1;
    localparam logic [1:0] ORI_EVEN = 2'd2;

    typedef struct packed {
        t_id  edge_vertex_a;
        t_id  edge_vertex_b;
        t_id  tetra_id;
        t_id  corner0;
        t_id  corner1;
        t_id  corner2;
        t_id  corner3;
        logic last_tetra;
    } t_in_word;

    typedef struct packed {
        t_id  ordered_tetra_id;
        t_pos ring_position;
        logic last_of_ring;
        logic on_border;
        logic overflow;
    } t_out_word;

    // One stored tetra: id, corners, off-edge pair
    typedef struct packed {
        t_id   id;
        t_quad corners;
        t_id   p0;
        t_id   p1;
    } t_entry;

    // Permutation parity of tst against ref; highest matching ref slot wins.
    function automatic logic [1:0] orient(t_quad ref_c, t_quad tst);
        logic [3:0][1:0] p;
        logic [3:0]      hit;
        logic            bad;
        logic            par;
        bad = 1'b0;
        par = 1'b0;
        for (int i = 0; i < 4; i++) begin
            hit[i] = 1'b0;
            p[i]   = 2'd0;
            for (int k = 0; k < 4; k++) begin
                if (ref_c[k] == tst[i]) begin
                    hit[i] = 1'b1;
                    p[i]   = 2'(k);
                end
            end
        end
        bad = ~&hit;
        for (int i = 0; i < 4; i++) begin
            for (int k = i + 1; k < 4; k++) begin
                if (p[i] == p[k]) bad = 1'b1;
                if (p[i] > p[k])  par = ~par;
            end
        end
        return bad ? ORI_BAD : (par ? ORI_ODD : ORI_EVEN);
    endfunction

endpackage

FILE: design/teo_if.sv
// Valid/ready channel interfaces for input tetras and ordered results.
interface teo_in_if import teo_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface teo_out_if import teo_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tetra_edge_ring_orderer.sv
// Orders the tetras around one mesh edge into an oriented ring.
//
// Usage:
//   i_in carries one tetra per word (edge ends, id, four corners, last flag).
//   Words are taken one per cycle while the block is loading. A word with
//   last_tetra set closes the shell and starts ordering; i_in.ready stays
//   low until the whole ring has been delivered on o_out.
//   Ordering is a search over the entry memory, each entry probe a read and
//   then a test. Each result then passes through ring memory read, entry
//   memory read, output register load and handoff.
//   o_out holds each word until it is taken; a stalled receiver just stops
//   the emission sequencer. Words beyond MAX_SHELL are dropped and the ring
//   reports overflow.
//   Reset (synchronous, active low) empties the store and clears the
//   output valid; memory contents are not cleared and need not be.
module tetra_edge_ring_orderer import teo_pkg::*; #(
    parameter int MAX_SHELL = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    teo_in_if.sink   i_in,
    teo_out_if.source o_out
);

    localparam int CW = $clog2(MAX_SHELL + 1);
    localparam int AW = (MAX_SHELL > 1) ? $clog2(MAX_SHELL) : 1;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_FIRST_RD = 4'd1;
    localparam logic [3:0] S_FIRST_EV = 4'd2;
    localparam logic [3:0] S_FWD_RD   = 4'd3;
    localparam logic [3:0] S_FWD_EV   = 4'd4;
    localparam logic [3:0] S_BWD_RD   = 4'd5;
    localparam logic [3:0] S_BWD_EV   = 4'd6;
    localparam logic [3:0] S_OUT_R1   = 4'd7;
    localparam logic [3:0] S_OUT_R2   = 4'd8;
    localparam logic [3:0] S_OUT_R3   = 4'd9;
    localparam logic [3:0] S_OUT_W    = 4'd10;

    // Storage
    t_entry           entry_mem [MAX_SHELL];
    logic [AW-1:0]    ring_mem  [MAX_SHELL];

    logic [3:0]       r_state;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    t_id              r_edge_a;
    t_id              r_edge_b;
    t_id              r_front;
    t_id              r_back;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_j;
    logic [CW-1:0]    r_fcnt;
    logic [CW-1:0]    r_bcnt;
    logic [CW-1:0]    r_k;
    logic             r_border;
    logic             r_out_valid;
    t_out_word        r_out;
    t_entry           r_ent_q;
    logic [AW-1:0]    r_ring_q;

    logic             in_acc;
    t_entry           new_ent;
    logic [AW-1:0]    ent_rd;
    logic [AW-1:0]    ring_rd;
    logic             ring_we;
    logic [AW-1:0]    ring_wa;
    logic [CW-1:0]    ring_len;
    logic [1:0]       first_ori;
    logic             fwd_a, fwd_b, bwd_a, bwd_b;
    logic [CW-1:0]    j_inc;
    logic [CW-1:0]    i_inc;

    assign i_in.ready  = (r_state == S_LOAD);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign in_acc      = i_in.valid && i_in.ready;
    assign ring_len    = r_fcnt + r_bcnt;
    assign j_inc       = r_j + 1'b1;
    assign i_inc       = r_i + 1'b1;

    // Off-edge pair: first two corners that are not edge ends, missing slots 0
    always_comb begin
        t_quad c;
        logic  got0, got1;
        c = {i_in.data.corner3, i_in.data.corner2, i_in.data.corner1, i_in.data.corner0};
        new_ent.id      = i_in.data.tetra_id;
        new_ent.corners = c;
        new_ent.p0      = '0;
        new_ent.p1      = '0;
        got0 = 1'b0;
        got1 = 1'b0;
        for (int m = 0; m < 4; m++) begin
            if (!got1 && c[m] != i_in.data.edge_vertex_a && c[m] != i_in.data.edge_vertex_b)
            begin
                if (!got0) begin
                    new_ent.p0 = c[m];
                    got0 = 1'b1;
                end else begin
                    new_ent.p1 = c[m];
                    got1 = 1'b1;
                end
            end
        end
    end

    // Match tests on the entry just read
    always_comb begin
        first_ori = orient(r_ent_q.corners, {r_ent_q.p1, r_ent_q.p0, r_edge_b, r_edge_a});
        fwd_a = (r_ent_q.p0 == r_back) &&
                (orient(r_ent_q.corners, {r_ent_q.p1, r_back, r_edge_b, r_edge_a}) == ORI_EVEN);
        fwd_b = (r_ent_q.p1 == r_back) &&
                (orient(r_ent_q.corners, {r_ent_q.p0, r_back, r_edge_b, r_edge_a}) == ORI_EVEN);
        bwd_a = (r_ent_q.p0 == r_front) &&
                (orient(r_ent_q.corners, {r_front, r_ent_q.p1, r_edge_b, r_edge_a}) == ORI_EVEN);
        bwd_b = (r_ent_q.p1 == r_front) &&
                (orient(r_ent_q.corners, {r_front, r_ent_q.p0, r_edge_b, r_edge_a}) == ORI_EVEN);
    end

    // Memory address selection
    always_comb begin
        ent_rd  = r_j[AW-1:0];
        ring_rd = '0;
        ring_we = 1'b0;
        ring_wa = '0;
        if (r_state == S_FIRST_RD) ent_rd = '0;
        if (r_state == S_OUT_R2)   ent_rd = r_ring_q;
        if (r_k < r_bcnt) begin
            ring_rd = AW'(CW'(MAX_SHELL) - r_bcnt + r_k);
        end else begin
            ring_rd = AW'(r_k - r_bcnt);
        end
        if (r_state == S_FIRST_EV) begin
            ring_we = 1'b1;
        end else if (r_state == S_FWD_EV && (fwd_a || fwd_b)) begin
            ring_we = 1'b1;
            ring_wa = r_fcnt[AW-1:0];
        end else if (r_state == S_BWD_EV && (bwd_a || bwd_b)) begin
            ring_we = 1'b1;
            ring_wa = AW'(CW'(MAX_SHELL - 1) - r_bcnt);
        end
    end

    // Memories: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CW'(MAX_SHELL)) begin
            entry_mem[r_count[AW-1:0]] <= new_ent;
        end
        r_ent_q <= entry_mem[ent_rd];
        if (ring_we) begin
            ring_mem[ring_wa] <= (r_state == S_FIRST_EV) ? '0 : r_j[AW-1:0];
        end
        r_ring_q <= ring_mem[ring_rd];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_edge_a    <= '0;
            r_edge_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_edge_a <= i_in.data.edge_vertex_a;
                        r_edge_b <= i_in.data.edge_vertex_b;
                        if (r_count < CW'(MAX_SHELL)) r_count <= r_count + 1'b1;
                        else                          r_ovf   <= 1'b1;
                        if (i_in.data.last_tetra) r_state <= S_FIRST_RD;
                    end
                end
                S_FIRST_RD: r_state <= S_FIRST_EV;
                S_FIRST_EV: begin
                    if (first_ori == ORI_EVEN) begin
                        r_front <= r_ent_q.p0;
                        r_back  <= r_ent_q.p1;
                    end else if (first_ori == ORI_ODD) begin
                        r_front <= r_ent_q.p1;
                        r_back  <= r_ent_q.p0;
                    end else begin
                        r_front <= '0;
                        r_back  <= '0;
                    end
                    r_fcnt   <= CW'(1);
                    r_bcnt   <= '0;
                    r_border <= 1'b0;
                    r_i      <= CW'(1);
                    r_j      <= CW'(1);
                    r_k      <= '0;
                    r_state  <= (r_count == CW'(1)) ? S_OUT_R1 : S_FWD_RD;
                end
                S_FWD_RD: r_state <= S_FWD_EV;
                S_FWD_EV: begin
                    if (fwd_a || fwd_b) begin
                        r_back  <= fwd_a ? r_ent_q.p1 : r_ent_q.p0;
                        r_fcnt  <= r_fcnt + 1'b1;
                        r_i     <= i_inc;
                        r_j     <= CW'(1);
                        r_state <= (i_inc == r_count) ? S_OUT_R1 : S_FWD_RD;
                    end else if (j_inc == r_count) begin
                        // forward chain broke: walk back from the front
                        r_border <= 1'b1;
                        r_j      <= '0;
                        r_state  <= S_BWD_RD;
                    end else begin
                        r_j     <= j_inc;
                        r_state <= S_FWD_RD;
                    end
                end
                S_BWD_RD: r_state <= S_BWD_EV;
                S_BWD_EV: begin
                    if (bwd_a || bwd_b || j_inc == r_count) begin
                        if (bwd_a || bwd_b) begin
                            r_front <= bwd_a ? r_ent_q.p1 : r_ent_q.p0;
                            r_bcnt  <= r_bcnt + 1'b1;
                        end
                        r_i     <= i_inc;
                        r_j     <= '0;
                        r_state <= (i_inc == r_count) ? S_OUT_R1 : S_BWD_RD;
                    end else begin
                        r_j     <= j_inc;
                        r_state <= S_BWD_RD;
                    end
                end
                S_OUT_R1: r_state <= S_OUT_R2;
                S_OUT_R2: r_state <= S_OUT_R3;
                S_OUT_R3: begin
                    r_out.ordered_tetra_id <= r_ent_q.id;
                    r_out.ring_position    <= POS_BITS'(r_k);
                    r_out.last_of_ring     <= (CW'(r_k + 1'b1) == ring_len);
                    r_out.on_border        <= r_border;
                    r_out.overflow         <= r_ovf;
                    r_out_valid            <= 1'b1;
                    r_state                <= S_OUT_W;
                end
                S_OUT_W: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last_of_ring) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_OUT_R1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

FILE: design/teo_checker.sv
// Port-level checks on the edge ring orderer, bound to the top level.
module teo_checker import teo_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed under stall");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // Loading and emission never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    // Mid-ring handoff keeps the input closed
    a_mid_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last_of_ring |=> !i_in_ready)
        else $error("input opened before ring end");

endmodule

bind tetra_edge_ring_orderer teo_checker u_teo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

FILE: dv/tb.sv
// Testbench for the edge ring orderer: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb;
    import teo_pkg::*;

    localparam int SHELL_CAP  = 32;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam t_id ID_ALL1   = '1;

    // Orientation answers of the predictor
    typedef enum int {ORIENT_NONE = -1, ORIENT_ODD = 0, ORIENT_EVEN = 1} t_orient;

    // Shell shapes produced by the random part
    typedef enum int {SHAPE_CLOSED, SHAPE_OPEN, SHAPE_NOISE} t_shape;

    // Predicts ordered rings from accepted tetras and checks delivered words
    class ring_scoreboard;
        t_id       edge_a, edge_b;
        t_quad     corners[SHELL_CAP];
        t_id       ids[SHELL_CAP];
        t_id       pair0[SHELL_CAP];
        t_id       pair1[SHELL_CAP];
        int        held;
        bit        dropped;
        t_out_word ring_q[$];
        int        errors;
        int        words_seen;
        int        rings_seen;
        int        border_rings;
        int        overflow_rings;

        function new();
            edge_a = '0; edge_b = '0; held = 0; dropped = 0;
            errors = 0; words_seen = 0; rings_seen = 0;
            border_rings = 0; overflow_rings = 0;
        endfunction

        // Parity of test corners against reference; last matching slot wins
        function t_orient parity(t_quad r, t_id t0, t_id t1, t_id t2, t_id t3);
            t_id tv[4];
            int  slot[4];
            int  used, flips, p;
            tv[0] = t0; tv[1] = t1; tv[2] = t2; tv[3] = t3;
            used = 0; flips = 0;
            for (int i = 0; i < 4; i++) begin
                p = 4;
                for (int k = 0; k < 4; k++) if (r[k] == tv[i]) p = k;
                if (p == 4 || used[p]) return ORIENT_NONE;
                used[p] = 1'b1;
                slot[p] = i;
            end
            for (int i = 0; i < 4; i++)
                for (int k = i + 1; k < 4; k++)
                    if (slot[i] > slot[k]) flips++;
            return flips[0] ? ORIENT_ODD : ORIENT_EVEN;
        endfunction

        // Take one accepted tetra; on the closing word, predict the ring
        function void note_tetra(t_in_word w);
            t_id fwd, bwd;
            int  ring[$];
            int  got, steps;
            bit  hit, broke;
            t_orient g;
            t_out_word o;
            edge_a = w.edge_vertex_a;
            edge_b = w.edge_vertex_b;
            if (held < SHELL_CAP) begin
                ids[held] = w.tetra_id;
                corners[held] = {w.corner3, w.corner2, w.corner1, w.corner0};
                pair0[held] = '0; pair1[held] = '0; got = 0;
                for (int c = 0; c < 4; c++) begin
                    if (got < 2 && corners[held][c] != edge_a &&
                        corners[held][c] != edge_b) begin
                        if (got == 0) pair0[held] = corners[held][c];
                        else pair1[held] = corners[held][c];
                        got++;
                    end
                end
                held++;
            end else begin
                dropped = 1'b1;
            end
            if (!w.last_tetra || held == 0) return;

            // seed the ring with the first tetra
            g = parity(corners[0], edge_a, edge_b, pair0[0], pair1[0]);
            fwd = '0; bwd = '0;
            if (g == ORIENT_EVEN) begin
                fwd = pair0[0]; bwd = pair1[0];
            end else if (g == ORIENT_ODD) begin
                fwd = pair1[0]; bwd = pair0[0];
            end
            ring = {ring, 0};
            steps = 0; broke = 0;
            // forward walk from the back vertex
            for (int i = 1; i < held; i++) begin
                hit = 0;
                for (int j = 1; j < held && !hit; j++) begin
                    if (pair0[j] == bwd &&
                        parity(corners[j], edge_a, edge_b, bwd, pair1[j]) == ORIENT_EVEN) begin
                        bwd = pair1[j]; hit = 1;
                    end else if (pair1[j] == bwd &&
                        parity(corners[j], edge_a, edge_b, bwd, pair0[j]) == ORIENT_EVEN) begin
                        bwd = pair0[j]; hit = 1;
                    end
                    if (hit && ring.size() < SHELL_CAP) ring = {ring, j};
                end
                if (!hit) begin
                    broke = 1;
                    break;
                end
                steps++;
            end
            // border: walk back from the front vertex and prepend
            if (broke) begin
                for (int i = steps + 1; i < held; i++) begin
                    hit = 0;
                    for (int j = 0; j < held && !hit; j++) begin
                        if (pair0[j] == fwd &&
                            parity(corners[j], edge_a, edge_b, pair1[j], fwd) == ORIENT_EVEN) begin
                            fwd = pair1[j]; hit = 1;
                        end else if (pair1[j] == fwd &&
                            parity(corners[j], edge_a, edge_b, pair0[j], fwd) == ORIENT_EVEN) begin
                            fwd = pair0[j]; hit = 1;
                        end
                        if (hit && ring.size() < SHELL_CAP) ring = {j, ring};
                    end
                end
            end
            foreach (ring[k]) begin
                o.ordered_tetra_id = ids[ring[k]];
                o.ring_position    = t_pos'(k);
                o.last_of_ring     = (k == ring.size() - 1);
                o.on_border        = broke;
                o.overflow         = dropped;
                ring_q = {ring_q, o};
            end
            rings_seen++;
            if (broke) border_rings++;
            if (dropped) overflow_rings++;
            held = 0;
            dropped = 0;
        endfunction

        // Compare one delivered word with the oldest predicted one
        function void check_word(t_out_word got);
            t_out_word want;
            words_seen++;
            if (ring_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: id=%0h pos=%0d last=%0b border=%0b ovf=%0b",
                             got.ordered_tetra_id, got.ring_position, got.last_of_ring,
                             got.on_border, got.overflow);
                return;
            end
            want = ring_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("word %0d expected: id=%0h pos=%0d last=%0b border=%0b ovf=%0b",
                             words_seen, want.ordered_tetra_id, want.ring_position,
                             want.last_of_ring, want.on_border, want.overflow);
                    $display("word %0d actual:   id=%0h pos=%0d last=%0b border=%0b ovf=%0b",
                             words_seen, got.ordered_tetra_id, got.ring_position,
                             got.last_of_ring, got.on_border, got.overflow);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    teo_in_if  tetra_ch ();
    teo_out_if ring_ch ();

    tetra_edge_ring_orderer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tetra_ch.sink),
        .o_out   (ring_ch.source)
    );

    ring_scoreboard sb;
    int  idle_pct;
    int  stall_pct;
    int  cycles;
    int  tetras_sent;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tetra_edge_ring_orderer: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, results taken at rising edge
    always @(negedge i_clk) ring_ch.ready = ($urandom_range(99) >= stall_pct);
    always @(posedge i_clk) begin
        if (i_rst_n && ring_ch.valid && ring_ch.ready) sb.check_word(ring_ch.data);
    end

    // Push one tetra word through the input handshake
    task automatic send_tetra(t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            tetra_ch.valid = 1'b0;
            tetra_ch.data  = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        tetra_ch.valid = 1'b1;
        tetra_ch.data  = w;
        do @(posedge i_clk); while (!tetra_ch.ready);
        sb.note_tetra(w);
        tetras_sent++;
        @(negedge i_clk);
        tetra_ch.valid = 1'b0;
    endtask

    // Corners a,b,x,y in random order with the requested parity
    function automatic t_quad arrange(t_id a, t_id b, t_id x, t_id y, bit even);
        t_id v[4];
        t_id tmp;
        int  j, inv;
        int  ix[4];
        v[0] = a; v[1] = b; v[2] = x; v[3] = y;
        for (int i = 0; i < 4; i++) ix[i] = i;
        for (int i = 3; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = t_id'(ix[i]); ix[i] = ix[j]; ix[j] = int'(tmp);
        end
        inv = 0;
        for (int i = 0; i < 4; i++)
            for (int k = i + 1; k < 4; k++)
                if (ix[i] > ix[k]) inv++;
        if (inv[0] == even) begin
            j = ix[0]; ix[0] = ix[1]; ix[1] = j;
        end
        return {v[ix[3]], v[ix[2]], v[ix[1]], v[ix[0]]};
    endfunction

    // Build one shell around a random edge and send it
    task automatic run_shell(int n, t_shape shape);
        t_in_word shell[$];
        t_in_word w, tmp;
        t_id a, b, base;
        t_quad q;
        int j;
        a = t_id'($urandom); b = t_id'($urandom); base = t_id'($urandom);
        for (int k = 0; k < n; k++) begin
            w.edge_vertex_a = a;
            w.edge_vertex_b = b;
            w.tetra_id = t_id'($urandom);
            if (shape == SHAPE_NOISE) begin
                for (int c = 0; c < 4; c++) begin
                    case ($urandom_range(5))
                        0: q[c] = a;
                        1: q[c] = b;
                        2: q[c] = base + t_id'($urandom_range(3));
                        3: q[c] = $urandom_range(1) ? ID_ALL1 : '0;
                        default: q[c] = t_id'($urandom);
                    endcase
                end
                if ($urandom_range(9) == 0) w.edge_vertex_a = t_id'($urandom);
            end else begin
                q = arrange(a, b, base + t_id'(k),
                            (shape == SHAPE_CLOSED && k == n - 1) ? base : base + t_id'(k + 1),
                            $urandom_range(14) != 0);
            end
            {w.corner3, w.corner2, w.corner1, w.corner0} = q;
            w.last_tetra = 1'b0;
            shell = {shell, w};
        end
        // random arrival order
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = shell[i]; shell[i] = shell[j]; shell[j] = tmp;
        end
        shell[n-1].last_tetra = 1'b1;
        foreach (shell[k]) send_tetra(shell[k]);
    endtask

    // Wait until every predicted word has come out
    task automatic drain();
        while (sb.ring_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    int shell_n;
    t_in_word dw;

    initial begin
        sb = new();
        idle_pct = 0; stall_pct = 0; tetras_sent = 0;
        i_rst_n = 1'b0;
        tetra_ch.valid = 1'b0;
        tetra_ch.data  = '0;
        ring_ch.ready  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single tetra, everything zero: no off-edge corners, bad orientation
        dw = '0; dw.last_tetra = 1'b1;
        send_tetra(dw);
        // single tetra, everything all ones
        dw = '1;
        send_tetra(dw);
        // odd-oriented single tetra, then one whose four corners are all off-edge
        dw = '{edge_vertex_a: 20'd5, edge_vertex_b: 20'd9, tetra_id: 20'h12345,
               corner0: 20'd9, corner1: 20'd5, corner2: 20'd7, corner3: 20'd8,
               last_tetra: 1'b1};
        send_tetra(dw);
        dw.corner0 = 20'd1; dw.corner1 = 20'd2; dw.corner2 = 20'd3; dw.corner3 = 20'd3;
        send_tetra(dw);
        // well-formed closed ring, open ring and a malformed shell
        run_shell(4, SHAPE_CLOSED);
        run_shell(3, SHAPE_OPEN);
        run_shell(5, SHAPE_NOISE);
        drain();

        // random part in four idle/stall phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            while (tetras_sent < 20 + 84 * (ph + 1)) begin
                case ($urandom_range(19))
                    0:       shell_n = $urandom_range(33, 35);
                    1:       shell_n = $urandom_range(9, 32);
                    default: shell_n = $urandom_range(1, 8);
                endcase
                case ($urandom_range(9))
                    0, 1:    run_shell(shell_n, SHAPE_NOISE);
                    2, 3, 4: run_shell(shell_n, SHAPE_OPEN);
                    default: run_shell(shell_n, SHAPE_CLOSED);
                endcase
            end
            // sender holds off until the pipeline is empty
            drain();
        end
        repeat (100) @(negedge i_clk);

        $display("covered %0d tetras in %0d rings, %0d words delivered",
                 tetras_sent, sb.rings_seen, sb.words_seen);
        $display("rings with border walk: %0d, rings with dropped tetras: %0d",
                 sb.border_rings, sb.overflow_rings);
        if (sb.errors == 0 && sb.ring_q.size() == 0) begin
            $display("tetra_edge_ring_orderer: match");
        end else begin
            $display("tetra_edge_ring_orderer: mismatch");
        end
        $finish;
    end
endmodule

FILE: files.f
design/teo_pkg.sv
design/teo_if.sv
design/tetra_edge_ring_orderer.sv
design/teo_checker.sv
dv/tb.sv
